// File: design/retransmit_queue_dup_ack_defines.svh
// Assertion macros shared by the RTL files.
`ifndef RETRANSMIT_QUEUE_DUP_ACK_DEFINES_SVH
`define RETRANSMIT_QUEUE_DUP_ACK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RQ_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RQ_ASSERT(label, clk, rst_n, prop, msg)
`define RQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: design/rqda_pkg.sv
`default_nettype none
package rqda_pkg;
  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned ThrW    = 8;

  localparam logic [1:0] ModePush  = 2'd0;
  localparam logic [1:0] ModeAck   = 2'd1;
  localparam logic [1:0] ModeFetch = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StStale = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SCAN, S_POP_RD, S_POP, S_OUT
  } rqda_state_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic take_in;     // latch the input word
    logic do_push;
    logic fetch_rd;    // start memory read at the send position
    logic fetch_done;  // capture fetch result
    logic ack_begin;   // classify the ack and start the scan
    logic scan_rd;     // issue read at scan offset
    logic scan_step;   // compare read data, advance scan
    logic pop_rd;      // read the head entry
    logic pop_step;    // compare head, pop if older
    logic emit;        // result word valid
  } rqda_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [1:0] mode;
    logic       can_fetch;
    logic       stale;
    logic       need_scan;
    logic       scan_last;
    logic       scan_hit;
    logic       do_pops;
    logic       pop_more;
  } rqda_sts_t;
endpackage
`default_nettype wire

// File: design/rqda_if.sv
`default_nettype none
interface rqda_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] seq_value;
  logic [15:0] pkt_handle;
  modport source (output valid, mode, seq_value, pkt_handle, input ready);
  modport sink (input valid, mode, seq_value, pkt_handle, output ready);
endinterface

interface rqda_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        out_valid;
  logic [15:0] out_handle;
  logic [31:0] out_seq;
  logic        resend_fired;
  modport source (output valid, status, out_valid, out_handle, out_seq, resend_fired,
                  input ready);
  modport sink (input valid, status, out_valid, out_handle, out_seq, resend_fired,
                output ready);
endinterface
`default_nettype wire

// File: design/rqda_ctrl.sv
`default_nettype none
`include "retransmit_queue_dup_ack_defines.svh"
module rqda_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire rqda_pkg::rqda_sts_t sts_i,
  output rqda_pkg::rqda_cmd_t      cmd_o
);
  import rqda_pkg::*;

  rqda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        // Dispatch the latched word by its mode.
        unique case (sts_i.mode)
          ModePush: begin
            cmd_o.do_push = 1'b1;
            state_d = S_OUT;
          end
          ModeFetch: begin
            if (sts_i.can_fetch) begin
              cmd_o.fetch_rd = 1'b1;
              state_d = S_SCAN;
            end else begin
              state_d = S_OUT;
            end
          end
          ModeAck: begin
            cmd_o.ack_begin = 1'b1;
            if (sts_i.stale || !sts_i.need_scan) begin
              state_d = S_OUT;
            end else begin
              cmd_o.scan_rd = 1'b1;
              state_d = S_SCAN;
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (sts_i.mode == ModeFetch) begin
          cmd_o.fetch_done = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_hit || sts_i.scan_last) begin
            state_d = sts_i.do_pops ? S_POP_RD : S_OUT;
          end else begin
            cmd_o.scan_rd = 1'b1;
          end
        end
      end
      S_POP_RD: begin
        if (sts_i.pop_more) begin
          cmd_o.pop_rd = 1'b1;
          state_d = S_POP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_POP: begin
        cmd_o.pop_step = 1'b1;
        state_d = S_POP_RD;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.emit = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `RQ_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> !out_valid_o, "ready while result pending")
  `RQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `RQ_ASSERT(a_take_next, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_RD), "word not taken")
endmodule
`default_nettype wire

// File: design/rqda_dp.sv
`default_nettype none
`include "retransmit_queue_dup_ack_defines.svh"
module rqda_dp #(
  parameter int unsigned QueueDepth = rqda_pkg::QueueDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          mode_i,
  input  wire logic [31:0]         seq_value_i,
  input  wire logic [15:0]         pkt_handle_i,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire rqda_pkg::rqda_cmd_t cmd_i,
  output rqda_pkg::rqda_sts_t      sts_o,
  output logic [1:0]               status_o,
  output logic                     out_valid_o,
  output logic [15:0]              out_handle_o,
  output logic [31:0]              out_seq_o,
  output logic                     resend_fired_o
);
  import rqda_pkg::*;

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(QueueDepth);

  logic [SeqW-1:0]    mem_seq [QueueDepth];
  logic [HandleW-1:0] mem_hdl [QueueDepth];
  logic [SeqW-1:0]    rd_seq_q;
  logic [HandleW-1:0] rd_hdl_q;

  logic [1:0]         mode_q;
  logic [SeqW-1:0]    seq_q;
  logic [HandleW-1:0] hdl_q;
  logic [AW-1:0]      head_q;
  logic [CW-1:0]      count_q, send_q, scan_q;
  logic [SeqW-1:0]    acked_q;
  logic [ThrW-1:0]    dup_q, thr_q;
  logic               newack_q;
  logic [1:0]         status_q;
  logic               oval_q, fired_q;
  logic [HandleW-1:0] ohdl_q;
  logic [SeqW-1:0]    oseq_q;

  logic [ThrW-1:0]    dup_inc;
  logic [SeqW-1:0]    target;
  logic               rd_en;
  logic [CW-1:0]      rd_off;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [CW:0]        rd_sum, wr_sum;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = v;
    if (r >= (CW+1)'(QueueDepth)) r = r - (CW+1)'(QueueDepth);
    return r[AW-1:0];
  endfunction

  assign dup_inc = dup_q + 8'd1;
  assign target  = newack_q ? seq_q : acked_q;

  // While scanning, prefetch the entry after the one being compared.
  always_comb begin
    rd_en  = cmd_i.fetch_rd | cmd_i.scan_rd | cmd_i.pop_rd;
    rd_off = cmd_i.fetch_rd ? send_q :
             (cmd_i.pop_rd ? '0 : (cmd_i.scan_step ? scan_q + 1'b1 : scan_q));
  end
  assign rd_sum  = {{(CW+1-AW){1'b0}}, head_q} + {1'b0, rd_off};
  assign wr_sum  = {{(CW+1-AW){1'b0}}, head_q} + {1'b0, count_q};
  assign rd_addr = wrap(rd_sum);
  assign wr_addr = wrap(wr_sum);

  // Queue storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push && count_q != DepthC) begin
      mem_seq[wr_addr] <= seq_q;
      mem_hdl[wr_addr] <= hdl_q;
    end
    if (rd_en) begin
      rd_seq_q <= mem_seq[rd_addr];
      rd_hdl_q <= mem_hdl[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      mode_q <= mode_i;
      seq_q  <= seq_value_i;
      hdl_q  <= pkt_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; count_q <= '0; send_q <= '0; scan_q <= '0;
      acked_q <= 32'd1; dup_q <= '0; thr_q <= 8'd3; newack_q <= 1'b0;
      status_q <= StOk; oval_q <= 1'b0; fired_q <= 1'b0;
      ohdl_q <= '0; oseq_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (cmd_i.take_in) begin
        status_q <= StOk; oval_q <= 1'b0; fired_q <= 1'b0;
        ohdl_q <= '0; oseq_q <= '0; newack_q <= 1'b0; scan_q <= '0;
      end
      if (cmd_i.do_push) begin
        if (count_q == DepthC) status_q <= StFull;
        else count_q <= count_q + 1'b1;
      end
      if (mode_q == ModeFetch && !cmd_i.take_in && !sts_o.can_fetch && !cmd_i.emit
          && !cmd_i.fetch_done && !cmd_i.fetch_rd)
        status_q <= StEmpty;
      if (cmd_i.fetch_rd) send_q <= send_q + 1'b1;
      if (cmd_i.fetch_done) begin
        oval_q <= 1'b1; ohdl_q <= rd_hdl_q; oseq_q <= rd_seq_q;
      end
      if (cmd_i.ack_begin) begin
        if (seq_q < acked_q) begin
          status_q <= StStale;
        end else if (seq_q == acked_q) begin
          if (dup_inc >= thr_q) dup_q <= '0;
          else dup_q <= dup_inc;
        end else begin
          dup_q <= '0; acked_q <= seq_q; newack_q <= 1'b1;
        end
      end
      if (cmd_i.scan_rd) scan_q <= cmd_i.ack_begin ? '0 : scan_q;
      if (cmd_i.scan_step) begin
        if (rd_seq_q == target) begin
          if (!newack_q) begin
            send_q <= scan_q; fired_q <= 1'b1;
          end else if (send_q < scan_q) begin
            send_q <= scan_q;
          end
        end
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.pop_step && rd_seq_q < seq_q) begin
        head_q <= wrap({{(CW+1-AW){1'b0}}, head_q} + (CW+1)'(1));
        count_q <= count_q - 1'b1;
        if (send_q != '0) send_q <= send_q - 1'b1;
      end
      if (cmd_i.pop_step && !(rd_seq_q < seq_q)) newack_q <= 1'b0;
    end
  end

  // pop_more: new ack, queue non-empty, and last pop compare did not stop.
  logic pop_stop_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pop_stop_q <= 1'b0;
    else if (cmd_i.take_in) pop_stop_q <= 1'b0;
    else if (cmd_i.pop_step && !(rd_seq_q < seq_q)) pop_stop_q <= 1'b1;
  end

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.can_fetch = (send_q < count_q);
    sts_o.stale     = (seq_q < acked_q);
    // Scan needed, when the queue is non-empty, for a new ack or a repeat that reaches the threshold.
    sts_o.need_scan = (count_q != '0) &&
                      ((seq_q > acked_q) || (dup_inc >= thr_q));
    sts_o.scan_last = (scan_q + 1'b1 >= count_q);
    sts_o.scan_hit  = (rd_seq_q == target);
    sts_o.do_pops   = newack_q;
    sts_o.pop_more  = newack_q && !pop_stop_q && (count_q != '0);
  end

  assign status_o       = status_q;
  assign out_valid_o    = oval_q;
  assign out_handle_o   = ohdl_q;
  assign out_seq_o      = oseq_q;
  assign resend_fired_o = fired_q;

  `RQ_ASSERT(a_send_le_count, clk_i, rst_ni, send_q <= count_q, "send position past tail")
  `RQ_ASSERT(a_count_le_depth, clk_i, rst_ni, count_q <= DepthC, "count overflow")
  `RQ_ASSERT(a_fire_no_fetch, clk_i, rst_ni, !(fired_q && oval_q), "fire with fetch")
endmodule
`default_nettype wire

// File: design/retransmit_queue_dup_ack.sv
// Push, nop and stale ack go from dispatch straight to the result; a fetch reads
// the entry at the send position; an ack needing a search scans up to QueueDepth
// entries, and a new ack then pops heads older than it. One word at a time: a new
// word is taken once the last result is delivered; one read port serves scan and pops.
// Reset: asynchronous active low; empty queue, last ack 1, threshold 3.
`default_nettype none
module retransmit_queue_dup_ack #(
  parameter int unsigned QueueDepth = rqda_pkg::QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  rqda_in_if.sink         in_if,
  rqda_out_if.source      out_if
);
  import rqda_pkg::*;

  rqda_cmd_t cmd;
  rqda_sts_t sts;

  // Controller sequences each word: latch, dispatch, scan, pop, deliver.
  rqda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath holds the queue memory, pointers and the result register.
  rqda_dp #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (in_if.mode),
    .seq_value_i    (in_if.seq_value),
    .pkt_handle_i   (in_if.pkt_handle),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (out_if.status),
    .out_valid_o    (out_if.out_valid),
    .out_handle_o   (out_if.out_handle),
    .out_seq_o      (out_if.out_seq),
    .resend_fired_o (out_if.resend_fired)
  );
endmodule
`default_nettype wire
